>>> sv/tbp_pkg.sv
`default_nettype none
package tbp_pkg;

  localparam int unsigned MaxHeight = 1024;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CfgWhiteMin   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRedMin     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgImageWidth = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLineBytes  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPlaneBytes = 3'd5;

  localparam logic [7:0]  WhiteMinRst   = 8'd200;
  localparam logic [7:0]  RedMinRst     = 8'd128;
  localparam logic [10:0] ImageWidthRst = 11'd152;
  localparam logic [10:0] ImageHeightRst = 11'd152;
  localparam logic [7:0]  LineBytesRst  = 8'd19;
  localparam logic [12:0] PlaneBytesRst = 13'd2888;

  // plane bits for one pixel
  typedef struct packed {
    logic mono;
    logic color;
  } plane_bits_t;

endpackage
`default_nettype wire

>>> sv/tbp_classify.sv
`default_nettype none
module tbp_classify (
  input  logic [7:0]          blue_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          white_min_i,
  input  logic [7:0]          red_min_i,
  output tbp_pkg::plane_bits_t bits_o
);

  logic is_white;
  logic is_red;

  assign is_white = (blue_i > white_min_i) && (green_i > white_min_i) &&
                    (red_i > white_min_i);
  assign is_red   = red_i > red_min_i;

  always_comb begin
    if (is_white) begin
      bits_o.mono  = 1'b1;
      bits_o.color = 1'b1;
    end else if (is_red) begin
      bits_o.mono  = 1'b0;
      bits_o.color = 1'b0;
    end else begin
      // black
      bits_o.mono  = 1'b0;
      bits_o.color = 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> sv/rgb_to_tricolor_bitplane_packer_top.sv
// Tricolour bitplane packer.
// Input stream: one 24-bit pixel per item on s_axis (blue low byte, red high
// byte), rows in bottom-up order. Each pixel is thresholded to white, red or
// black and packed MSB first into a black/white byte and a red byte.
// Output stream: one item per full byte or row end on m_axis, carrying both
// plane bytes and the byte offset in the planes; tlast marks the pair of an
// image's last pixel. Pixels past line_bytes of a row are counted and dropped.
// Each pixel passes through the input register, then the result register.
// Throughput: one pixel per clock while m_axis does not stall, set by the single
// pass of threshold, shift and offset logic between those two registers.
// When m_axis stalls, the result register holds and the input register
// fills; s_axis_tready_o falls only once both are occupied.
// Configuration: cfg_we_i writes register cfg_idx_i (0 white_min, 1 red_min,
// 2 image_width, 3 image_height, 4 line_bytes, 5 plane_bytes); the user must write only
// while idle, which the block does not enforce. The plane base is reloaded from
// plane_bytes - line_bytes at each image start. PLANE_DEPTH must be a power of two;
// offsets wrap modulo PLANE_DEPTH. Reset (rst_ni low, asynchronous) restores register
// defaults, empties both stages and returns the pixel counters to the start of an image.
`default_nettype none
module rgb_to_tricolor_bitplane_packer_top #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned PLANE_DEPTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tbp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [7:0] blue_level, [15:8] green_level, [23:16] red_level
  input  logic [23:0]                  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [7:0] mono_byte, [15:8] color_byte, [27:16] plane_offset, [31:28] zero
  output logic [31:0]                  m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpW  = ((WW > 11) ? WW : 11) + 1;
  localparam int unsigned PdW   = $clog2(PLANE_DEPTH);
  localparam int unsigned BaseW = (PdW > 13) ? PdW : 13;
  localparam int unsigned SumW  = ((PdW > ColW) ? PdW : ColW) + 1;

  // configuration registers
  logic [7:0]  white_min_q, red_min_q, line_bytes_q;
  logic [10:0] image_width_q, image_height_q;
  logic [12:0] plane_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_min_q    <= tbp_pkg::WhiteMinRst;
      red_min_q      <= tbp_pkg::RedMinRst;
      image_width_q  <= tbp_pkg::ImageWidthRst;
      image_height_q <= tbp_pkg::ImageHeightRst;
      line_bytes_q   <= tbp_pkg::LineBytesRst;
      plane_bytes_q  <= tbp_pkg::PlaneBytesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbp_pkg::CfgWhiteMin:    white_min_q    <= cfg_data_i[7:0];
        tbp_pkg::CfgRedMin:      red_min_q      <= cfg_data_i[7:0];
        tbp_pkg::CfgImageWidth:  image_width_q  <= cfg_data_i[10:0];
        tbp_pkg::CfgImageHeight: image_height_q <= cfg_data_i[10:0];
        tbp_pkg::CfgLineBytes:   line_bytes_q   <= cfg_data_i[7:0];
        tbp_pkg::CfgPlaneBytes:  plane_bytes_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic        in_valid_q;
  logic [23:0] pix_q;
  logic        adv;
  logic        out_valid_q;
  logic        out_free;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign adv             = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      pix_q <= s_axis_tdata_i;
    end
  end

  tbp_pkg::plane_bits_t bits;

  tbp_classify u_classify (
    .blue_i      (pix_q[7:0]),
    .green_i     (pix_q[15:8]),
    .red_i       (pix_q[23:16]),
    .white_min_i (white_min_q),
    .red_min_i   (red_min_q),
    .bits_o      (bits)
  );

  // packing state
  logic [7:0]     mono_q, color_q, mono_d, color_d;
  logic [ColW-1:0] col_q, col_d;
  logic [9:0]     row_q, row_d;
  logic [PdW-1:0] base_q, base_d;

  logic [CmpW-1:0]  iw_ext, w_clamp;
  logic [11:0]      h_clamp;
  logic [2:0]       pos;
  logic [7:0]       mask;
  logic [BaseW-1:0] first_diff;
  logic [PdW-1:0]   first_base, base_now, base_step;
  logic [SumW-1:0]  off_sum;
  logic [PdW+11:0]  off_ext;
  logic             row_end, last, emit;
  logic [ColW-1:0]  byte_idx;

  assign iw_ext = CmpW'(image_width_q);

  always_comb begin
    if (image_width_q == 11'd0) begin
      w_clamp = CmpW'(1);
    end else if (iw_ext > CmpW'(MAX_WIDTH)) begin
      w_clamp = CmpW'(MAX_WIDTH);
    end else begin
      w_clamp = iw_ext;
    end
    if (image_height_q == 11'd0) begin
      h_clamp = 12'd1;
    end else if (12'(image_height_q) > 12'(tbp_pkg::MaxHeight)) begin
      h_clamp = 12'(tbp_pkg::MaxHeight);
    end else begin
      h_clamp = 12'(image_height_q);
    end
  end

  assign pos        = col_q[2:0];
  assign mask       = 8'h80 >> pos;
  assign byte_idx   = col_q >> 3;
  assign first_diff = BaseW'(plane_bytes_q) - BaseW'(line_bytes_q);
  assign first_base = first_diff[PdW-1:0];
  assign base_now   = (col_q == '0 && row_q == '0) ? first_base : base_q;
  assign base_step  = base_now - PdW'(line_bytes_q);

  assign row_end = (CmpW'(col_q) + CmpW'(1)) >= w_clamp;
  assign last    = row_end && ((12'(row_q) + 12'd1) >= h_clamp);
  assign emit    = (CmpW'(byte_idx) < CmpW'(line_bytes_q)) && (pos == 3'd7 || row_end);

  assign off_sum = SumW'(base_now) + SumW'(byte_idx);
  assign off_ext = (PdW + 12)'(off_sum[PdW-1:0]);

  always_comb begin
    mono_d  = (pos == 3'd0) ? 8'h00 : mono_q;
    color_d = (pos == 3'd0) ? 8'h00 : color_q;
    mono_d  = bits.mono  ? (mono_d | mask)  : (mono_d & ~mask);
    color_d = bits.color ? (color_d | mask) : (color_d & ~mask);
    base_d  = base_now;
    row_d   = row_q;
    col_d   = col_q + ColW'(1);
    if (row_end) begin
      col_d = '0;
      if (last) begin
        row_d = '0;
      end else begin
        row_d  = row_q + 10'd1;
        base_d = base_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q  <= 8'h00;
      color_q <= 8'h00;
      col_q   <= '0;
      row_q   <= '0;
      base_q  <= '0; // reloaded at the first pixel of an image
    end else if (adv) begin
      mono_q  <= mono_d;
      color_q <= color_d;
      col_q   <= col_d;
      row_q   <= row_d;
      base_q  <= base_d;
    end
  end

  // result register
  logic [31:0] out_data_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_data_q <= {4'h0, off_ext[11:0], color_d, mono_d};
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // a white mono bit never comes without its colour bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_data_q[7:0] & ~out_data_q[15:8]) == 8'h00))
    else $error("mono bit set where colour bit is clear");

  // the last pixel of an image returns the counters to the image start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last |=> (col_q == '0) && (row_q == '0))
    else $error("counters not cleared after image end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MAX_WIDTH && 32'(row_q) < tbp_pkg::MaxHeight)
    else $error("pixel counter out of range");

  // an empty input register always takes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input stalled while input register empty");

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned PlaneDepth = 4096;

  typedef struct packed {
    logic        done;
    logic [11:0] offset;
    logic [7:0]  color;
    logic [7:0]  mono;
  } plane_pair_t;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [tbp_pkg::CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [tbp_pkg::CfgDataW-1:0] cfg_data_i      = '0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  // [7:0] blue_level, [15:8] green_level, [23:16] red_level
  logic [23:0]                  s_axis_tdata_i  = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  // [7:0] mono_byte, [15:8] color_byte, [27:16] plane_offset, [31:28] zero
  logic [31:0]                  m_axis_tdata_o;
  logic                         m_axis_tlast_o;

  rgb_to_tricolor_bitplane_packer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // packer copy: settings and pixel counters
  int unsigned white_min, red_min, img_width, img_height, line_bytes, plane_bytes;
  int unsigned column_idx, row_idx, row_base;
  logic [7:0]  mono_acc, color_acc;

  plane_pair_t pairs_due[$];
  int unsigned pixels_taken, pairs_checked, reg_writes, mismatches;
  bit          steady = 1'b0;

  always #4 clk_i = ~clk_i;

  function automatic void pack_pixel(logic [23:0] px);
    int unsigned w, h, pos;
    logic [7:0]  blue, green, red, mask;
    bit          row_end, last_px;
    plane_pair_t pair;
    {red, green, blue} = px;
    w = (img_width == 0) ? 1 : ((img_width > MaxWidth) ? MaxWidth : img_width);
    h = (img_height == 0) ? 1 :
        ((img_height > tbp_pkg::MaxHeight) ? tbp_pkg::MaxHeight : img_height);
    // plane base only reloads at the first pixel of an image
    if (column_idx == 0 && row_idx == 0)
      row_base = ((plane_bytes % PlaneDepth) + PlaneDepth - line_bytes) % PlaneDepth;
    pos  = column_idx % 8;
    mask = 8'h80 >> pos;
    if (pos == 0) begin
      mono_acc  = '0;
      color_acc = '0;
    end
    if (blue > white_min && green > white_min && red > white_min) begin
      mono_acc  |= mask;
      color_acc |= mask;
    end else if (red > red_min) begin
      mono_acc  &= ~mask;
      color_acc &= ~mask;
    end else begin
      mono_acc  &= ~mask;
      color_acc |= mask;
    end
    row_end = (column_idx + 1) >= w;
    last_px = row_end && (row_idx + 1) >= h;
    if ((column_idx / 8) < line_bytes && (pos == 7 || row_end)) begin
      pair.mono   = mono_acc;
      pair.color  = color_acc;
      pair.offset = 12'((row_base + column_idx / 8) % PlaneDepth);
      pair.done   = last_px;
      pairs_due.push_back(pair);
    end
    if (row_end) begin
      column_idx = 0;
      if (last_px) begin
        row_idx = 0;
      end else begin
        row_idx++;
        row_base = (row_base + PlaneDepth - line_bytes) % PlaneDepth;
      end
    end else begin
      column_idx++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      pack_pixel(s_axis_tdata_i);
      pixels_taken++;
    end
  end

  always @(posedge clk_i) begin
    plane_pair_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pairs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pair, tdata %h last %b", $time, m_axis_tdata_o,
                   m_axis_tlast_o);
      end else begin
        want = pairs_due.pop_front();
        pairs_checked++;
        if ({4'h0, want.offset, want.color, want.mono} !== m_axis_tdata_o ||
            want.done !== m_axis_tlast_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: pair mismatch: expected mono %h color %h offset %0d last %b,",
                      " got tdata %h last %b"},
                     $time, want.mono, want.color, want.offset, want.done,
                     m_axis_tdata_o, m_axis_tlast_o);
        end
      end
    end
  end

  always @(posedge clk_i) m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 32);

  task automatic write_reg(input logic [tbp_pkg::CfgIdxW-1:0] idx,
                           input logic [tbp_pkg::CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tbp_pkg::CfgWhiteMin:    white_min   = value[7:0];
      tbp_pkg::CfgRedMin:      red_min     = value[7:0];
      tbp_pkg::CfgImageWidth:  img_width   = value[10:0];
      tbp_pkg::CfgImageHeight: img_height  = value[10:0];
      tbp_pkg::CfgLineBytes:   line_bytes  = value[7:0];
      tbp_pkg::CfgPlaneBytes:  plane_bytes = value[12:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red);
    while (!steady && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {red, green, blue};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic hold_for_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pairs_due.size() != 0);
  endtask

  // a dropped pixel leaves nothing to wait for, so give the pipeline time too
  task automatic settle();
    hold_for_results();
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [7:0] near_threshold();
    logic [7:0] lvl;
    lvl = $urandom_range(0, 1) ? 8'(white_min) : 8'(red_min);
    case ($urandom_range(0, 5))
      0:       return lvl;
      1:       return lvl + 8'd1;
      2:       return lvl - 8'd1;
      3:       return 8'h00;
      4:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                             int unsigned usual);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, usual);
    endcase
  endfunction

  task automatic test_classify();
    // default thresholds: white above 200, red above 128
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd200, 8'd255, 8'd255);
    send_pixel(8'd201, 8'd201, 8'd201);
    send_pixel(8'd255, 8'd255, 8'd128);
    send_pixel(8'd0,   8'd0,   8'd129);
    send_pixel(8'd255, 8'd200, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd200);
    send_pixel(8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_shrink_mid_row();
    settle();
    // width falls below the current column and height of zero means one row
    write_reg(tbp_pkg::CfgImageWidth, tbp_pkg::CfgDataW'(4));
    write_reg(tbp_pkg::CfgImageHeight, tbp_pkg::CfgDataW'(0));
    send_pixel(8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_tail_and_wrap();
    settle();
    write_reg(tbp_pkg::CfgWhiteMin, tbp_pkg::CfgDataW'(0));
    write_reg(tbp_pkg::CfgRedMin, tbp_pkg::CfgDataW'(255));
    write_reg(tbp_pkg::CfgImageWidth, tbp_pkg::CfgDataW'(3));
    write_reg(tbp_pkg::CfgImageHeight, tbp_pkg::CfgDataW'(2));
    write_reg(tbp_pkg::CfgLineBytes, tbp_pkg::CfgDataW'(2));
    // base sits below zero and wraps to the top of the plane
    write_reg(tbp_pkg::CfgPlaneBytes, tbp_pkg::CfgDataW'(1));
    repeat (2) begin
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd255);
    end
  endtask

  task automatic test_dropped_pixels();
    settle();
    write_reg(tbp_pkg::CfgWhiteMin, tbp_pkg::CfgDataW'(255));
    write_reg(tbp_pkg::CfgRedMin, tbp_pkg::CfgDataW'(0));
    write_reg(tbp_pkg::CfgImageWidth, tbp_pkg::CfgDataW'(10));
    write_reg(tbp_pkg::CfgImageHeight, tbp_pkg::CfgDataW'(1));
    write_reg(tbp_pkg::CfgLineBytes, tbp_pkg::CfgDataW'(1));
    write_reg(tbp_pkg::CfgPlaneBytes, tbp_pkg::CfgDataW'(8191));
    // the last two pixels fall past the line, so no pair closes the image
    repeat (5) begin
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0,   8'd0,   8'd0);
    end
    settle();
    write_reg(tbp_pkg::CfgLineBytes, tbp_pkg::CfgDataW'(0));
    write_reg(tbp_pkg::CfgImageWidth, tbp_pkg::CfgDataW'(2));
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
  endtask

  task automatic test_full_width();
    settle();
    // one pixel with a 1x1 image puts the counters back at an image start
    write_reg(tbp_pkg::CfgImageWidth, tbp_pkg::CfgDataW'(1));
    write_reg(tbp_pkg::CfgImageHeight, tbp_pkg::CfgDataW'(1));
    send_pixel(8'd0, 8'd0, 8'd0);
    settle();
    write_reg(tbp_pkg::CfgImageWidth, tbp_pkg::CfgDataW'(2047));
    write_reg(tbp_pkg::CfgLineBytes, tbp_pkg::CfgDataW'(128));
    write_reg(tbp_pkg::CfgPlaneBytes, tbp_pkg::CfgDataW'(4096));
    steady <= 1'b1;
    repeat (MaxWidth) send_pixel(near_threshold(), near_threshold(), near_threshold());
    steady <= 1'b0;
  endtask

  task automatic test_random_stream();
    int unsigned sent, burst;
    sent = 0;
    while (sent < 450) begin
      settle();
      if ($urandom_range(0, 2) != 0)
        write_reg(tbp_pkg::CfgWhiteMin, tbp_pkg::CfgDataW'(pick_value(0, 255, 255)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tbp_pkg::CfgRedMin, tbp_pkg::CfgDataW'(pick_value(0, 255, 255)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tbp_pkg::CfgImageWidth, tbp_pkg::CfgDataW'(pick_value(0, 2047, 24)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tbp_pkg::CfgImageHeight, tbp_pkg::CfgDataW'(pick_value(0, 2047, 5)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tbp_pkg::CfgLineBytes, tbp_pkg::CfgDataW'(pick_value(0, 255, 4)));
      if ($urandom_range(0, 2) != 0)
        write_reg(tbp_pkg::CfgPlaneBytes, tbp_pkg::CfgDataW'(pick_value(0, 8191, 8191)));
      burst = $urandom_range(1, 80);
      repeat (burst) begin
        send_pixel(near_threshold(), near_threshold(), near_threshold());
        if ($urandom_range(0, 49) == 0) hold_for_results();
      end
      sent += burst;
    end
  endtask

  initial begin
    white_min   = tbp_pkg::WhiteMinRst;
    red_min     = tbp_pkg::RedMinRst;
    img_width   = tbp_pkg::ImageWidthRst;
    img_height  = tbp_pkg::ImageHeightRst;
    line_bytes  = tbp_pkg::LineBytesRst;
    plane_bytes = tbp_pkg::PlaneBytesRst;
    column_idx  = 0;
    row_idx     = 0;
    row_base    = 0;
    mono_acc    = '0;
    color_acc   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_classify();
    test_shrink_mid_row();
    test_tail_and_wrap();
    test_dropped_pixels();
    test_full_width();
    test_random_stream();
    settle();

    $display("run covered %0d pixels and %0d register writes, %0d plane byte pairs compared",
             pixels_taken, reg_writes, pairs_checked);
    $display("mismatches: %0d, pairs still outstanding: %0d", mismatches, pairs_due.size());
    if (mismatches == 0 && pairs_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timed out waiting for the packer");
    $display("FAILURE");
    $finish;
  end

endmodule
